// ===== rtl/fpa_pkg.sv =====
// shared constants and types for the q24.8 fixed-point alu
`timescale 1ns / 1ps
package fpa_pkg;
  localparam int unsigned FRAC_BITS_DEF = 8;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3, OP_MIN = 4'd4,
    OP_MAX = 4'd5, OP_INC = 4'd6, OP_DEC = 4'd7, OP_FROM_INT = 4'd8,
    OP_TO_INT = 4'd9
  } func_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_DIV_ZERO = 2'd1, ST_OVERFLOW = 2'd2
  } status_t;

  // compare flags for one item
  typedef struct packed {
    logic gt;
    logic lt;
    logic eq;
  } flags_t;
endpackage

// ===== rtl/fpa_div.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module fpa_div #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned DEN_W = 32
) (
  input  logic             clk,
  input  logic             adv,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W:0]   rem
);
  // per stage: partial remainder, remaining numerator bits, quotient so far
  logic [DEN_W:0]   rem_s [NUM_W+1];
  logic [NUM_W-1:0] num_s [NUM_W+1];
  logic [NUM_W-1:0] quo_s [NUM_W+1];
  logic [DEN_W-1:0] den_s [NUM_W+1];

  assign rem_s[0] = '0;
  assign num_s[0] = num;
  assign quo_s[0] = '0;
  assign den_s[0] = den;

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [DEN_W+1:0] trial;
    logic [DEN_W+1:0] shifted;
    assign shifted = {rem_s[i], num_s[i][NUM_W-1]};
    assign trial = shifted - {2'b00, den_s[i]};
    // registered step
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!trial[DEN_W+1]) begin
          rem_s[i+1] <= trial[DEN_W:0];
          quo_s[i+1] <= {quo_s[i][NUM_W-2:0], 1'b1};
        end else begin
          rem_s[i+1] <= shifted[DEN_W:0];
          quo_s[i+1] <= {quo_s[i][NUM_W-2:0], 1'b0};
        end
        num_s[i+1] <= {num_s[i][NUM_W-2:0], 1'b0};
        den_s[i+1] <= den_s[i];
      end
    end
  end

  assign quo = quo_s[NUM_W];
  assign rem = rem_s[NUM_W];
endmodule

// ===== rtl/fixed_point_alu_q24_8_unit.sv =====
// q24.8 fixed-point alu with stream ports
// pipeline: stage 1, stage 2, the divider stages, the rounding stage and the output register
// throughput: one item per cycle; the pipeline advances whenever the output can take
// an item, so results keep their order and a stall holds every stage
// reset: rst synchronously clears all valid bits; data registers are not reset
`timescale 1ns / 1ps
module fixed_point_alu_q24_8_unit #(
  parameter int unsigned FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // func[3:0], operand_a[35:4], operand_b[67:36], zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // result[31:0], a_greater, a_less, a_equal, status[36:35]
);
  import fpa_pkg::*;

  localparam int unsigned NUM_W = DATA_W + FRAC_BITS;
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned DEPTH = NUM_W + 4;

  logic adv;
  logic [DEPTH-1:0] vld;

  // the whole pipe moves when the output register is free or being drained
  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;

  // stage 1: unpack, magnitudes, simple ops, multiply
  logic [3:0] func_in;
  logic signed [DATA_W-1:0] a_in, b_in;
  assign func_in = s_tdata[3:0];
  assign a_in = s_tdata[35:4];
  assign b_in = s_tdata[67:36];

  logic [3:0] f1;
  flags_t fl1;
  logic signed [DATA_W+1:0] simple1;
  logic signed [PROD_W-1:0] prod1;
  logic [DATA_W-1:0] ma1, mb1;
  logic neg_q1, bz1;

  logic signed [DATA_W+1:0] simple_c;
  logic signed [DATA_W+1:0] ax, bx;
  logic signed [DATA_W+FRAC_BITS-1:0] shl;
  logic signed [DATA_W-1:0] shr;
  assign ax = {{2{a_in[DATA_W-1]}}, a_in};
  assign bx = {{2{b_in[DATA_W-1]}}, b_in};
  assign shl = {a_in, FRAC_BITS'(0)};
  assign shr = a_in >>> FRAC_BITS;

  // operations done without the multiplier or divider
  always_comb begin
    case (func_in)
      OP_ADD:   simple_c = ax + bx;
      OP_SUB:   simple_c = ax - bx;
      OP_MIN:   simple_c = (a_in < b_in) ? ax : bx;
      OP_MAX:   simple_c = (a_in > b_in) ? ax : bx;
      OP_INC:   simple_c = ax + (DATA_W+2)'(1);
      OP_DEC:   simple_c = ax - (DATA_W+2)'(1);
      OP_FROM_INT: begin
        if (shl > $signed({{(FRAC_BITS+1){1'b0}}, {(DATA_W-1){1'b1}}}))
          simple_c = (DATA_W+2)'(64'sh7FFFFFFF) + (DATA_W+2)'(1);
        else if (shl < $signed({{(FRAC_BITS+1){1'b1}}, {(DATA_W-1){1'b0}}}))
          simple_c = -(DATA_W+2)'(64'sh7FFFFFFF) - (DATA_W+2)'(2);
        else
          simple_c = shl[DATA_W+1:0];
      end
      OP_TO_INT: simple_c = {{2{shr[DATA_W-1]}}, shr};
      default:  simple_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1 <= func_in;
      fl1 <= '{gt: a_in > b_in, lt: a_in < b_in, eq: a_in == b_in};
      simple1 <= simple_c;
      prod1 <= PROD_W'(a_in) * PROD_W'(b_in);
      ma1 <= a_in[DATA_W-1] ? DATA_W'(-a_in) : DATA_W'(a_in);
      mb1 <= b_in[DATA_W-1] ? DATA_W'(-b_in) : DATA_W'(b_in);
      neg_q1 <= a_in[DATA_W-1] ^ b_in[DATA_W-1];
      bz1 <= (b_in == '0);
    end
  end

  // stage 2: round product magnitude, feed divider
  logic [PROD_W-1:0] pmag;
  assign pmag = prod1[PROD_W-1] ? PROD_W'(-prod1) : PROD_W'(prod1);
  logic [PROD_W-1:0] mulq2;

  always_ff @(posedge clk) begin
    if (adv) mulq2 <= (pmag >> FRAC_BITS) + PROD_W'(pmag[FRAC_BITS-1]);
  end

  // side data carried alongside the divider
  typedef struct packed {
    logic [3:0] f;
    flags_t fl;
    logic signed [DATA_W+1:0] simple;
    logic neg_m;
    logic neg_q;
    logic bz;
    logic [PROD_W-1:0] mulq;
  } side_t;

  side_t side [NUM_W+1];
  logic neg_m1;
  assign neg_m1 = prod1[PROD_W-1];
  logic [3:0] f2; flags_t fl2; logic signed [DATA_W+1:0] simple2;
  logic nm2, nq2, bz2;
  always_ff @(posedge clk) begin
    if (adv) begin
      f2 <= f1; fl2 <= fl1; simple2 <= simple1; nm2 <= neg_m1; nq2 <= neg_q1; bz2 <= bz1;
    end
  end
  assign side[0] = '{f: f2, fl: fl2, simple: simple2, neg_m: nm2, neg_q: nq2, bz: bz2,
                     mulq: mulq2};
  for (genvar i = 0; i < NUM_W; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv) side[i+1] <= side[i];
    end
  end

  // divider operands are registered in stage 2, alongside the side data
  logic [NUM_W-1:0] num2;
  logic [DATA_W-1:0] den2;
  always_ff @(posedge clk) begin
    if (adv) begin
      num2 <= {ma1, FRAC_BITS'(0)};
      den2 <= bz1 ? DATA_W'(1) : mb1;
    end
  end
  logic [NUM_W-1:0] dq;
  logic [DATA_W:0] dr;
  logic [DATA_W-1:0] den_d [NUM_W+1];
  assign den_d[0] = den2;
  for (genvar i = 0; i < NUM_W; i++) begin : g_den
    always_ff @(posedge clk) begin
      if (adv) den_d[i+1] <= den_d[i];
    end
  end
  fpa_div #(.NUM_W(NUM_W), .DEN_W(DATA_W)) u_div (
    .clk(clk), .adv(adv), .num(num2), .den(den2), .quo(dq), .rem(dr)
  );

  // stage after divider: round quotient, pick result magnitude
  side_t sd;
  assign sd = side[NUM_W];
  logic [PROD_W-1:0] mag3;
  logic neg3;
  side_t side3;
  always_ff @(posedge clk) begin
    if (adv) begin
      side3 <= sd;
      if (sd.f == OP_MUL) begin
        mag3 <= sd.mulq;
        neg3 <= sd.neg_m;
      end else begin
        mag3 <= PROD_W'(dq) + PROD_W'(({dr, 1'b0}) >= {2'b00, den_d[NUM_W]});
        neg3 <= sd.neg_q;
      end
    end
  end

  // final stage: saturate and pack into the output register
  logic [DATA_W-1:0] res_c;
  logic [1:0] st_c;
  logic [PROD_W-1:0] lim;
  assign lim = neg3 ? (PROD_W'(1) << (DATA_W-1)) : ((PROD_W'(1) << (DATA_W-1)) - PROD_W'(1));
  always_comb begin
    res_c = '0;
    st_c = ST_OK;
    case (side3.f)
      OP_MUL, OP_DIV: begin
        if (side3.f == OP_DIV && side3.bz) begin
          res_c = '0;
          st_c = ST_DIV_ZERO;
        end else if (mag3 > lim) begin
          res_c = neg3 ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
          st_c = ST_OVERFLOW;
        end else begin
          res_c = neg3 ? DATA_W'(-mag3) : DATA_W'(mag3);
        end
      end
      OP_ADD, OP_SUB, OP_INC, OP_DEC, OP_FROM_INT: begin
        if (side3.simple > $signed({3'b000, {(DATA_W-1){1'b1}}})) begin
          res_c = {1'b0, {(DATA_W-1){1'b1}}};
          st_c = ST_OVERFLOW;
        end else if (side3.simple < $signed({3'b111, {(DATA_W-1){1'b0}}})) begin
          res_c = {1'b1, {(DATA_W-1){1'b0}}};
          st_c = ST_OVERFLOW;
        end else begin
          res_c = side3.simple[DATA_W-1:0];
        end
      end
      OP_MIN, OP_MAX, OP_TO_INT: res_c = side3.simple[DATA_W-1:0];
      default: res_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) m_tdata <= {3'b000, st_c, side3.fl.eq, side3.fl.lt, side3.fl.gt, res_c};
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], s_tvalid};
    end
  end
  assign m_tvalid = vld[DEPTH-1];

  // a stalled result must hold
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");
  // flags are exclusive
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot({m_tdata[32], m_tdata[33], m_tdata[34]}))
    else $error("compare flags not one-hot");
  // status code in range
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[36:35] != 2'd3)
    else $error("bad status");
endmodule

// ===== test/fixed_point_alu_q24_8_unit_checker.sv =====
// checker for the q24.8 alu: watches both stream channels, predicts and compares
`timescale 1ns / 1ps
module fixed_point_alu_q24_8_unit_checker #(
  parameter int unsigned FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  output int          errors,
  output int          pending,
  output int          results_seen
);
  import fpa_pkg::*;

  localparam longint MAX32 = 64'sd2147483647;
  localparam longint MIN32 = -64'sd2147483648;

  // expected result words, oldest first
  logic [39:0] alu_expected_q[$];

  function automatic longint clamp32(input longint v, inout status_t st);
    if (v > MAX32) begin
      st = ST_OVERFLOW;
      return MAX32;
    end
    if (v < MIN32) begin
      st = ST_OVERFLOW;
      return MIN32;
    end
    return v;
  endfunction

  // exact fixed-point result word for one operation
  function automatic logic [39:0] alu_predict(input logic [71:0] d);
    func_t            op;
    longint           a, b, r, p;
    longint unsigned  m, q, rem, num, den;
    status_t          st;
    op = func_t'(d[3:0]);
    a = longint'($signed(d[35:4]));
    b = longint'($signed(d[67:36]));
    st = ST_OK;
    r = 0;
    case (op)
      OP_ADD: r = clamp32(a + b, st);
      OP_SUB: r = clamp32(a - b, st);
      OP_MUL: begin
        p = a * b;
        m = (p < 0) ? -p : p;
        q = m >> FRAC_BITS;
        rem = m & ((64'd1 << FRAC_BITS) - 1);
        if (rem >= (64'd1 << (FRAC_BITS - 1))) q++;
        r = clamp32((p < 0) ? -longint'(q) : longint'(q), st);
      end
      OP_DIV: begin
        if (b == 0) st = ST_DIV_ZERO;
        else begin
          num = ((a < 0) ? -a : a) << FRAC_BITS;
          den = (b < 0) ? -b : b;
          q = num / den;
          rem = num % den;
          if (2 * rem >= den) q++;
          r = clamp32(((a < 0) != (b < 0)) ? -longint'(q) : longint'(q), st);
        end
      end
      OP_MIN: r = (a < b) ? a : b;
      OP_MAX: r = (a > b) ? a : b;
      OP_INC: r = clamp32(a + 1, st);
      OP_DEC: r = clamp32(a - 1, st);
      OP_FROM_INT: r = clamp32(a * (64'sd1 <<< FRAC_BITS), st);
      OP_TO_INT: r = a >>> FRAC_BITS;
      default: r = 0;
    endcase
    return {1'b0, st, a == b, a < b, a > b, r[31:0]};
  endfunction

  assign pending = alu_expected_q.size();

  // predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    logic [39:0] exp_w;
    if (rst) begin
      errors <= 0;
      results_seen <= 0;
      alu_expected_q.delete();
    end else begin
      if (s_tvalid && s_tready) alu_expected_q.push_back(alu_predict(s_tdata));
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (alu_expected_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_tdata);
          errors <= errors + 1;
        end else begin
          exp_w = alu_expected_q.pop_front();
          if (exp_w[31:0] !== m_tdata[31:0] || exp_w[32] !== m_tdata[32] ||
              exp_w[33] !== m_tdata[33] || exp_w[34] !== m_tdata[34] ||
              exp_w[36:35] !== m_tdata[36:35]) begin
            $display("%0t: mismatch expected res=%h gt=%b lt=%b eq=%b st=%0d", $time,
                     exp_w[31:0], exp_w[32], exp_w[33], exp_w[34], exp_w[36:35]);
            $display("%0t:          actual   res=%h gt=%b lt=%b eq=%b st=%0d", $time,
                     m_tdata[31:0], m_tdata[32], m_tdata[33], m_tdata[34], m_tdata[36:35]);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ===== test/fixed_point_alu_q24_8_unit_tb.sv =====
// testbench top for the q24.8 alu: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
module fixed_point_alu_q24_8_unit_tb;
  import fpa_pkg::*;

  localparam int RANDOM_ITEMS = 1330;
  localparam int LATENCY = FRAC_BITS_DEF + 36;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  int          errors, pending, results_seen;
  int          cycles = 0;
  bit          hold_off = 1'b0;
  int          items_sent = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  fixed_point_alu_q24_8_unit dut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  fixed_point_alu_q24_8_unit_checker chk (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .pending(pending), .results_seen(results_seen)
  );

  // operand value biased toward extremes and small numbers
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff - $urandom_range(0, 3);
      1: return 32'h80000000 + $urandom_range(0, 3);
      2: return $urandom_range(0, 8);
      3: return -$urandom_range(0, 2048);
      4: return $urandom_range(0, 65535) << $urandom_range(0, 16);
      default: return $urandom;
    endcase
  endfunction

  // offer one item and hold it until the transfer
  task automatic send_op(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, b, a, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic go_idle(input int n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // receiver: stall pattern, plus one long hold-off
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_off) m_tready <= 1'b0;
    else m_tready <= (cycles[9:8] == 2'd3) ? 1'b1 : ($urandom_range(0, 3) != 0);
  end

  initial begin
    wait (items_sent == 300);
    hold_off = 1'b1;
    repeat (150) @(posedge clk);
    hold_off = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [31:0] a;
    logic [3:0]  op;
    int          burst;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, every operation, special cases
    send_op(OP_ADD, 32'h7fffffff, 32'h00000001);
    send_op(OP_SUB, 32'h80000000, 32'h00000001);
    send_op(OP_MUL, 32'h7fffffff, 32'h7fffffff);
    send_op(OP_MUL, 32'hffffff80, 32'h00000001);
    send_op(OP_MUL, 32'h00000080, 32'h00000001);
    send_op(OP_DIV, 32'h00000100, 32'h00000000);
    send_op(OP_DIV, 32'h80000000, 32'h00000001);
    send_op(OP_DIV, 32'h00000100, 32'h00000300);
    send_op(OP_DIV, 32'hffffff00, 32'h00000200);
    send_op(OP_MIN, 32'h00001234, 32'h00001234);
    send_op(OP_MAX, 32'h80000000, 32'h7fffffff);
    send_op(OP_INC, 32'h7fffffff, 32'h0);
    send_op(OP_DEC, 32'h80000000, 32'h0);
    send_op(OP_FROM_INT, 32'h00800000, 32'h0);
    send_op(OP_FROM_INT, 32'hff7fffff, 32'h0);
    send_op(OP_FROM_INT, 32'hfffffffd, 32'h0);
    send_op(OP_TO_INT, 32'hffffff01, 32'h0);
    send_op(OP_TO_INT, 32'h7fffffff, 32'h0);
    send_op(4'd10, 32'h5, 32'h3);
    send_op(4'd15, 32'hffffffff, 32'hffffffff);
    // sender pause until everything is back
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    // random bursts with random gaps
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      burst = $urandom_range(0, 9);
      op = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
      a = pick_operand();
      send_op(op, a, ($urandom_range(0, 7) == 0) ? a : pick_operand());
      if (burst == 0) go_idle($urandom_range(1, 6));
    end
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d items over all ten operations and unused codes", items_sent);
    $display("%0d results compared, with saturation, divide by zero and long stalls", results_seen);
    if (errors == 0 && pending == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
